// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros; each expects clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every edge out of reset.
`define KTS_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("kts: invariant violated");

// Antecedent implies consequent in the same cycle.
`define KTS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kts: same-cycle implication violated");

// Antecedent implies consequent in the next cycle.
`define KTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kts: next-cycle implication violated");

`endif

// ===== hdl/kts_pkg.sv =====
// ----------------------------------------------------------------------------
// kts_pkg
// Constants, codes and types shared by the registration table modules.
// ----------------------------------------------------------------------------
package kts_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int KEY_BITS    = 32;
  localparam int HANDLE_BITS = 16;
  localparam int COUNT_BITS  = $clog2(TABLE_DEPTH + 1);

  localparam int ACTION_BITS = 2;
  localparam int STATUS_BITS = 2;

  typedef enum logic [ACTION_BITS-1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_REMOVE = 2'd2
  } action_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_DUP     = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  // Per-cell control, driven by the top level.
  typedef struct packed {
    logic capture;   // register the key compare result
    logic occupied;  // cell holds a live entry
    logic append;    // write the new entry here
    logic shift;     // remove: cells at or after the hit take their right neighbor
  } cell_ctl_t;

endpackage

// ===== hdl/kts_cell.sv =====
// ----------------------------------------------------------------------------
// kts_cell
// One table entry: stored key and handle, local key compare, chained hit.
// ----------------------------------------------------------------------------
module kts_cell (
  input  logic                           clk,
  input  kts_pkg::cell_ctl_t             ctl,
  input  logic [kts_pkg::KEY_BITS-1:0]    cmp_key,
  input  logic [kts_pkg::KEY_BITS-1:0]    new_key,
  input  logic [kts_pkg::HANDLE_BITS-1:0] new_handle,
  input  logic [kts_pkg::KEY_BITS-1:0]    next_key,
  input  logic [kts_pkg::HANDLE_BITS-1:0] next_handle,
  input  logic                           seen_in,
  input  logic [kts_pkg::HANDLE_BITS-1:0] found_in,
  output logic [kts_pkg::KEY_BITS-1:0]    entry_key,
  output logic [kts_pkg::HANDLE_BITS-1:0] entry_handle,
  output logic                           match,
  output logic                           seen_out,
  output logic [kts_pkg::HANDLE_BITS-1:0] found_out
);
  import kts_pkg::*;

  // Hit at or left of this cell; found handle accumulates down the row.
  assign seen_out  = seen_in | match;
  assign found_out = found_in | (match ? entry_handle : '0);

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      match <= ctl.occupied && (entry_key == cmp_key);
    end
    if (ctl.append) begin
      entry_key    <= new_key;
      entry_handle <= new_handle;
    end else if (ctl.shift && seen_out) begin
      entry_key    <= next_key;
      entry_handle <= next_handle;
    end
  end

endmodule

// ===== hdl/keyed_registration_table.sv =====
// ----------------------------------------------------------------------------
// keyed_registration_table
// Linear-search key/handle table built as a row of entry cells.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one request: action (lookup,
//   insert, remove), key and handle. Output channel (out_valid/out_ready)
//   returns one result per request: status, found_handle, entry_count.
//   Every cell compares its key against the incoming key at the edge the
//   request is accepted; the update state then resolves the hit, applies
//   the append or the remove and registers the result, raising out_valid,
//   once the result register is free or being drained. A new request is
//   taken only in the idle state, after the update of the last one is done.
//   A remove closes the gap by shifting every entry right of the hit one
//   cell to the left; entries stay packed and keys stay unique.
//   The result register parts the two sides: a new request is accepted
//   while a result still waits, and its update holds until that result is
//   taken. When the receiver stalls, the table does not change.
//   Reset empties the table (entry count zero) and drops any pending result;
//   cell contents are left as they are and read only below the count.
// ----------------------------------------------------------------------------
module keyed_registration_table (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [kts_pkg::ACTION_BITS-1:0]   action,
  input  logic [kts_pkg::KEY_BITS-1:0]      key,
  input  logic [kts_pkg::HANDLE_BITS-1:0]   handle,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [kts_pkg::STATUS_BITS-1:0]   status,
  output logic [kts_pkg::HANDLE_BITS-1:0]   found_handle,
  output logic [kts_pkg::COUNT_BITS-1:0]    entry_count
);
  import kts_pkg::*;

  `include "assert_macros.svh"

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_UPDATE = 2'b10
  } state_t;

  state_t                 state, state_next;

  // Captured request.
  logic [ACTION_BITS-1:0] req_action;
  logic [KEY_BITS-1:0]    req_key;
  logic [HANDLE_BITS-1:0] req_handle;

  logic [COUNT_BITS-1:0]  occupied_count, occupied_count_next;

  // Row signals.
  cell_ctl_t              cell_ctl    [TABLE_DEPTH];
  logic [KEY_BITS-1:0]    cell_key    [TABLE_DEPTH];
  logic [HANDLE_BITS-1:0] cell_handle [TABLE_DEPTH];
  logic [HANDLE_BITS-1:0] cell_found  [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] cell_seen;
  logic [TABLE_DEPTH-1:0] match_vec;

  logic                   accept;
  logic                   fire;
  logic                   hit;
  logic                   full;
  logic                   do_append;
  logic                   do_shift;
  logic [STATUS_BITS-1:0] status_next;
  logic [HANDLE_BITS-1:0] found_next;

  assign in_ready    = (state == S_IDLE);
  assign accept      = in_valid && in_ready;
  // Update only when the result register is free or being drained.
  assign fire        = (state == S_UPDATE) && (!out_valid || out_ready);
  assign hit         = cell_seen[TABLE_DEPTH-1];
  assign full        = (occupied_count == COUNT_BITS'(TABLE_DEPTH));
  assign entry_count = occupied_count;

  // Resolve the request from the registered compare results.
  always_comb begin
    status_next         = ST_OK;
    found_next          = '0;
    occupied_count_next = occupied_count;
    do_append           = 1'b0;
    do_shift            = 1'b0;
    unique case (req_action)
      ACT_LOOKUP: begin
        if (hit) begin
          found_next = cell_found[TABLE_DEPTH-1];
        end else begin
          status_next = ST_MISSING;
        end
      end
      ACT_INSERT: begin
        // Full is checked before duplicate.
        if (full) begin
          status_next = ST_FULL;
        end else if (hit) begin
          status_next = ST_DUP;
        end else begin
          do_append           = 1'b1;
          occupied_count_next = occupied_count + COUNT_BITS'(1);
        end
      end
      ACT_REMOVE: begin
        if (hit) begin
          found_next          = cell_found[TABLE_DEPTH-1];
          do_shift            = 1'b1;
          occupied_count_next = occupied_count - COUNT_BITS'(1);
        end else begin
          status_next = ST_MISSING;
        end
      end
      default: begin
        // Unused action code: no change, ok with zero handle.
      end
    endcase
  end

  // Row of entry cells; hit and handle ripple left to right.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic [KEY_BITS-1:0]    nbr_key;
    logic [HANDLE_BITS-1:0] nbr_handle;
    logic                   seen_prev;
    logic [HANDLE_BITS-1:0] found_prev;

    if (i == TABLE_DEPTH - 1) begin : g_last
      // Rightmost cell takes don't-care data; it falls out of the count.
      assign nbr_key    = '0;
      assign nbr_handle = '0;
    end else begin : g_mid
      assign nbr_key    = cell_key[i+1];
      assign nbr_handle = cell_handle[i+1];
    end

    if (i == 0) begin : g_first
      assign seen_prev  = 1'b0;
      assign found_prev = '0;
    end else begin : g_rest
      assign seen_prev  = cell_seen[i-1];
      assign found_prev = cell_found[i-1];
    end

    assign cell_ctl[i].capture  = accept;
    assign cell_ctl[i].occupied = (COUNT_BITS'(i) < occupied_count);
    assign cell_ctl[i].append   = fire && do_append &&
                                  (COUNT_BITS'(i) == occupied_count);
    assign cell_ctl[i].shift    = fire && do_shift;

    kts_cell u_cell (
      .clk          (clk),
      .ctl          (cell_ctl[i]),
      .cmp_key      (key),
      .new_key      (req_key),
      .new_handle   (req_handle),
      .next_key     (nbr_key),
      .next_handle  (nbr_handle),
      .seen_in      (seen_prev),
      .found_in     (found_prev),
      .entry_key    (cell_key[i]),
      .entry_handle (cell_handle[i]),
      .match        (match_vec[i]),
      .seen_out     (cell_seen[i]),
      .found_out    (cell_found[i])
    );
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (accept) state_next = S_UPDATE;
      S_UPDATE: if (fire) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      occupied_count <= '0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (fire) begin
        occupied_count <= occupied_count_next;
        out_valid      <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload: hold the request, load the result on update.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_action <= action;
      req_key    <= key;
      req_handle <= handle;
    end
    if (fire) begin
      status       <= status_next;
      found_handle <= found_next;
    end
  end

  // Count never passes the table depth.
  `KTS_ASSERT_ALWAYS(a_count_bound, occupied_count <= COUNT_BITS'(TABLE_DEPTH))
  // Keys are unique, so at most one live cell can hit.
  `KTS_ASSERT_IMPL(a_single_hit, state == S_UPDATE, $onehot0(match_vec))
  // A stalled result freezes the table size.
  `KTS_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, $stable(occupied_count))
  // An update changes the count by at most one.
  `KTS_ASSERT_NEXT(a_count_step, fire,
                   (occupied_count == $past(occupied_count)) ||
                   (occupied_count == $past(occupied_count) + COUNT_BITS'(1)) ||
                   (occupied_count == $past(occupied_count) - COUNT_BITS'(1)))

endmodule
